@@ rtl/core/ntc_code_to_temperature_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the core
// Clocked, reset-qualified property wrappers.
// ----------------------------------------------------------------------------
`ifndef NTC_CODE_TO_TEMPERATURE_CORE_DEFINES_SVH
`define NTC_CODE_TO_TEMPERATURE_CORE_DEFINES_SVH

// implication checked on every clock outside reset
`define NTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntc_pkg
// Curve tables, field widths and the job record passed front to back.
// ----------------------------------------------------------------------------
package ntc_pkg;

	localparam int CODE_W   = 16;
	localparam int TEMP_W   = 11;
	localparam int STORED   = 25;
	localparam int SEG_W    = 5;
	localparam int FRAC_W   = 6;   // 50*diff/den < 50
	localparam int DIFF_W   = 22;  // 50*diff fits

	localparam logic REG_TABLE_SELECT = 1'b0;

	typedef logic [CODE_W-1:0] code_t;

	// classified item handed from front to back
	typedef struct packed {
		logic             in_range;
		logic [SEG_W-1:0] seg;
		code_t            diff;   // table[k] - code
		code_t            den;    // table[k] - table[k+1]
	} job_t;

	function automatic code_t curve_335(input logic [SEG_W-1:0] i);
		code_t r;
		case (i)
			5'd0: r = 16'h65B6;  5'd1: r = 16'h64EE;  5'd2: r = 16'h63FD;
			5'd3: r = 16'h62DD;  5'd4: r = 16'h618A;  5'd5: r = 16'h5FFF;
			5'd6: r = 16'h5E35;  5'd7: r = 16'h5C29;  5'd8: r = 16'h59D6;
			5'd9: r = 16'h573D;  5'd10: r = 16'h545E; 5'd11: r = 16'h513F;
			5'd12: r = 16'h4DE5; 5'd13: r = 16'h4A5A; 5'd14: r = 16'h46A7;
			5'd15: r = 16'h42D8; 5'd16: r = 16'h3EF7; 5'd17: r = 16'h3B10;
			5'd18: r = 16'h372D; 5'd19: r = 16'h335A; 5'd20: r = 16'h2F9F;
			5'd21: r = 16'h2C05; 5'd22: r = 16'h2894; 5'd23: r = 16'h2552;
			5'd24: r = 16'h2242;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

	function automatic code_t curve_505(input logic [SEG_W-1:0] i);
		code_t r;
		case (i)
			5'd0: r = 16'h91C7;  5'd1: r = 16'h8DD7;  5'd2: r = 16'h88F6;
			5'd3: r = 16'h8313;  5'd4: r = 16'h7C29;  5'd5: r = 16'h7446;
			5'd6: r = 16'h6B90;  5'd7: r = 16'h623E;  5'd8: r = 16'h5897;
			5'd9: r = 16'h4EE8;  5'd10: r = 16'h457B; 5'd11: r = 16'h3C90;
			5'd12: r = 16'h3454; 5'd13: r = 16'h2CE4; 5'd14: r = 16'h264C;
			5'd15: r = 16'h2088; 5'd16: r = 16'h1B8F; 5'd17: r = 16'h174F;
			5'd18: r = 16'h13B3; 5'd19: r = 16'h10A7; 5'd20: r = 16'h0E17;
			5'd21: r = 16'h0BEF; 5'd22: r = 16'h0A21; 5'd23: r = 16'h089D;
			5'd24: r = 16'h0757;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

	function automatic code_t curve(input logic sel, input logic [SEG_W-1:0] i);
		return sel ? curve_505(i) : curve_335(i);
	endfunction

endpackage

@@ rtl/core/ntc_code_to_temperature_core.sv @@
// Latency: the result follows the input transfer through the segment scan, hand-off,
//   queue and back load, and the divider; codes out of span skip the scan and divider.
// Throughput: front and back each take a new item only when done with the last;
//   a two-entry queue lets them overlap; without output stalls the scan sets the rate.
// Reset: arst_n clears all control state and loads table_select with 1.
// ----------------------------------------------------------------------------
// ntc_code_to_temperature_core
// NTC converter code to temperature in tenths of a degree, linear interpolation.
// ----------------------------------------------------------------------------
module ntc_code_to_temperature_core import ntc_pkg::*; #(
	parameter int TABLE_ENTRIES = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] adc_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [10:0] temp_tenths,
	output logic        in_range
);

	`include "ntc_code_to_temperature_core_defines.svh"

	localparam int USED = (TABLE_ENTRIES < STORED) ? TABLE_ENTRIES : STORED;

	logic table_select_q;
	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_job, b_job;

	assign pready = 1'b1;
	assign prdata = (paddr[1] == REG_TABLE_SELECT) ? {31'd0, table_select_q} : 32'd0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_select_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[1] == REG_TABLE_SELECT) begin
			table_select_q <= pwdata[0];
		end
	end

	ntc_front #(.USED(USED)) u_front (
		.clk, .arst_n, .table_select(table_select_q),
		.in_valid, .in_ready, .adc_code,
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	ntc_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
	);

	ntc_back u_back (
		.clk, .arst_n,
		.job_valid(b_valid), .job_ready(b_ready), .job(b_job),
		.out_valid, .out_ready, .temp_tenths, .in_range
	);

	`NTC_ASSERT_IMP(a_ready_const, 1'b1, pready, "pready low")
	`NTC_ASSERT_IMP(a_job_den, b_valid && b_job.in_range, b_job.den != '0, "zero divisor")
	`NTC_ASSERT_IMP(a_job_diff, b_valid && b_job.in_range, b_job.diff < b_job.den, "diff beyond segment")

endmodule

@@ rtl/core/ntc_front.sv @@
// ----------------------------------------------------------------------------
// ntc_front
// Range check and segment search, one table entry per cycle.
// ----------------------------------------------------------------------------
module ntc_front import ntc_pkg::*; #(
	parameter int USED = 25
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  table_select,
	input  logic  in_valid,
	output logic  in_ready,
	input  code_t adc_code,
	output logic  job_valid,
	input  logic  job_ready,
	output job_t  job
);

	localparam logic [SEG_W-1:0] LAST = SEG_W'(USED - 1);
	localparam logic [SEG_W-1:0] KMAX = SEG_W'(USED - 2);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SEND} state_t;

	state_t           state_q;
	code_t            code_q;
	logic [SEG_W-1:0] k_q;
	job_t             job_q;
	code_t            t_hi, t_lo;

	assign t_hi = curve(table_select, k_q);
	assign t_lo = curve(table_select, k_q + SEG_W'(1));

	assign in_ready  = (state_q == ST_IDLE);
	assign job_valid = (state_q == ST_SEND);
	assign job       = job_q;

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			code_q  <= '0;
			job_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						code_q <= adc_code;
						k_q    <= '0;
						if (adc_code <= curve(table_select, '0) &&
						    adc_code > curve(table_select, LAST)) begin
							state_q <= ST_SCAN;
						end else begin
							job_q   <= '0;
							state_q <= ST_SEND;
						end
					end
				end
				ST_SCAN: begin
					if ((t_hi >= code_q && code_q > t_lo) || k_q == KMAX) begin
						job_q.in_range <= 1'b1;
						job_q.seg      <= k_q;
						job_q.diff     <= t_hi - code_q;
						job_q.den      <= t_hi - t_lo;
						state_q        <= ST_SEND;
					end else begin
						k_q <= k_q + SEG_W'(1);
					end
				end
				ST_SEND: begin
					if (job_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/ntc_queue.sv @@
// ----------------------------------------------------------------------------
// ntc_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module ntc_queue import ntc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_job,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_job
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/core/ntc_back.sv @@
// ----------------------------------------------------------------------------
// ntc_back
// Restoring divider for the interpolation fraction, then output register.
// ----------------------------------------------------------------------------
module ntc_back import ntc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  job_t              job,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [TEMP_W-1:0] temp_tenths,
	output logic              in_range
);

	`include "ntc_code_to_temperature_core_defines.svh"

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

	state_t             state_q;
	logic [DIFF_W-1:0]  rem_q;
	code_t              den_q;
	logic [FRAC_W-1:0]  quo_q;
	logic [2:0]         cnt_q;
	logic [SEG_W-1:0]   seg_q;
	logic               rng_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [DIFF_W-1:0]  trial;
	logic signed [TEMP_W-1:0] base;
	logic [FRAC_W-1:0]  quo_fin;
	logic               rem_nz;
	logic               rnd_up;

	// shifted divisor for the current quotient bit
	assign trial = {{(DIFF_W-CODE_W){1'b0}}, den_q} << cnt_q;
	// 50*k - 200
	assign base  = TEMP_W'(signed'({1'b0, seg_q}) * 50) - TEMP_W'(200);

	// last quotient bit and leftover remainder
	assign quo_fin = (rem_q >= trial) ? (quo_q | FRAC_W'(1)) : quo_q;
	assign rem_nz  = (rem_q >= trial) ? (rem_q != trial) : (rem_q != '0);
	// below zero degrees the truncation toward zero rounds the fraction up
	assign rnd_up  = base[TEMP_W-1] && rem_nz;

	assign job_ready   = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign temp_tenths = temp_q;
	assign in_range    = rng_q;

	// divide sequencer: 50*diff / den, six quotient bits MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			den_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			seg_q   <= '0;
			rng_q   <= 1'b0;
			temp_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						rng_q <= job.in_range;
						seg_q <= job.seg;
						den_q <= job.den;
						rem_q <= DIFF_W'(job.diff) * DIFF_W'(50);
						quo_q <= '0;
						cnt_q <= 3'(FRAC_W - 1);
						if (job.in_range) begin
							state_q <= ST_DIV;
						end else begin
							temp_q  <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						quo_q[cnt_q] <= 1'b1;
					end
					if (cnt_q == 3'd0) begin
						state_q <= ST_OUT;
						temp_q  <= base + TEMP_W'(quo_fin + FRAC_W'(rnd_up));
					end else begin
						cnt_q <= cnt_q - 3'd1;
					end
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`NTC_ASSERT_IMP(a_zero_when_invalid, out_valid && !in_range, temp_tenths == '0, "nonzero invalid")
	`NTC_ASSERT_IMP(a_frac_bound, state_q == ST_OUT && rng_q, temp_q >= base && temp_q <= base + TEMP_W'(50), "fraction out of segment")
	`NTC_ASSERT_NEXT(a_div_done, state_q == ST_DIV && cnt_q == 3'd0, state_q == ST_OUT, "divider overrun")

endmodule
